@@ rtl/core/multi_voice_sample_mixer_macros.svh @@
// Assertion macros for the voice mixer.
`ifndef MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH
`define MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH
// Check that a condition implies a consequence on the same edge.
`define MVSM_ASSERT_IMP(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Check that a condition implies a consequence on the next edge.
`define MVSM_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

@@ rtl/core/mvsm_pkg.sv @@
// Types, constants and state codes for the voice mixer.
package mvsm_pkg;
   localparam int NumVoicesDef = 16;
   localparam int SampleWordsDef = 65536;
   localparam logic [15:0] RateReset = 16'd256;
   localparam logic [5:0] VolReset = 6'd43;
   localparam logic [5:0] VolMax = 6'd63;
   localparam int VolShift = 5;

   typedef enum logic [3:0] {
      CMD_TICK = 4'd0, CMD_WRITE = 4'd1, CMD_START = 4'd2, CMD_STOP = 4'd3,
      CMD_PAUSE = 4'd4, CMD_RESUME = 4'd5, CMD_PLAY = 4'd6, CMD_REWIND = 4'd7,
      CMD_REPEAT = 4'd8, CMD_POS = 4'd9, CMD_RATE = 4'd10, CMD_VOL = 4'd11,
      CMD_QUERY = 4'd12
   } cmd_type;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_UNUSED = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_READ, S_ACC, S_DONE
   } state_type;

   typedef struct packed {
      logic [3:0] command;
      logic [3:0] voice;
      logic signed [31:0] value;
      logic [15:0] address;
      logic signed [7:0] sample_in;
      logic [16:0] sample_count;
      logic mode;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mix_sample;
      logic clipped;
      logic [1:0] status;
      logic [3:0] voice_index;
      logic voice_active;
   } rsp_type;
endpackage

@@ rtl/core/mvsm_ram.sv @@
// Generic single-port RAM with registered read.
module mvsm_ram #(
   parameter int Width = 8,
   parameter int Depth = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_ff;

   // read one word a cycle and, when enabled, write it
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end
   assign rd_data = rd_ff;
endmodule

@@ rtl/core/multi_voice_sample_mixer.sv @@
// Top level of the voice mixer: slot table, tick sequencer and sample memory.
//  channel | ports                      | handshake
//  request | req_start, req_busy, req   | taken when start high and busy low
//  result  | rsp_valid, rsp             | one-cycle strobe, no backpressure
// Non-tick commands pass through scan and done before the result strobe.
// A tick visits each slot in turn (scan, read, accumulate if playing, else
// scan only), then done; the single memory read port and accumulator set this.
// Busy is high from acceptance until the result strobe.
// Synchronous reset clears the slot table; sample memory is not cleared.
module multi_voice_sample_mixer #(
   parameter int NumVoices = mvsm_pkg::NumVoicesDef,
   parameter int SampleWords = mvsm_pkg::SampleWordsDef
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_start,
   output logic             req_busy,
   input  mvsm_pkg::req_type req,
   output logic             rsp_valid,
   output mvsm_pkg::rsp_type rsp
);
   localparam int VW = (NumVoices > 1) ? $clog2(NumVoices) : 1;
   localparam int AW = $clog2(SampleWords);

   mvsm_pkg::state_type state_ff, state_in;
   mvsm_pkg::req_type cmd_ff;
   logic [VW-1:0] idx_ff, idx_in;
   logic signed [17:0] sum_ff, sum_in;
   logic rsp_valid_ff;
   mvsm_pkg::rsp_type rsp_ff, rsp_in;

   logic [NumVoices-1:0] in_use_ff, playing_ff, mode_ff;
   logic [15:0] start_ff [NumVoices];
   logic [15:0] last_ff [NumVoices];
   logic [23:0] pos_ff [NumVoices];
   logic [15:0] rate_ff [NumVoices];
   logic [5:0] vol_ff [NumVoices];
   logic signed [15:0] rep_ff [NumVoices];

   // memory port
   logic mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0] mem_rd;
   logic [15:0] cur_idx;
   logic [AW:0] wide_addr;

   mvsm_ram #(.Width(8), .Depth(SampleWords)) u_ram (
      .clock(clock), .wr_en(mem_we), .addr(mem_addr),
      .wr_data(cmd_ff.sample_in), .rd_data(mem_rd));

   assign cur_idx = pos_ff[idx_ff][23:8];
   assign wide_addr = {1'b0, AW'(start_ff[idx_ff])} + {1'b0, AW'(cur_idx)};
   assign mem_we = (state_ff == mvsm_pkg::S_SCAN) &&
                   (cmd_ff.command == mvsm_pkg::CMD_WRITE);
   assign mem_addr = mem_we ? AW'(cmd_ff.address) : wide_addr[AW-1:0];

   // lowest free slot
   logic free_found;
   logic [VW-1:0] free_idx;
   always_comb begin
      free_found = 1'b0;
      free_idx = '0;
      for (int i = NumVoices - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx = VW'(i);
         end
      end
   end

   // addressed slot check
   logic addr_ok;
   logic [VW-1:0] k;
   assign k = VW'(cmd_ff.voice);
   assign addr_ok = (32'(cmd_ff.voice) < NumVoices) && in_use_ff[k];

   // per-voice product, rounded down, in mode 1; mode 0 adds the raw sample
   logic signed [14:0] prod;
   logic [13:0] mag;
   logic signed [9:0] fancy_add;
   logic signed [9:0] add_val;
   assign prod = $signed(mem_rd) * $signed({1'b0, vol_ff[idx_ff]});
   assign mag = prod[14] ? 14'(-prod) : prod[13:0];
   always_comb begin
      if (prod[14]) begin
         fancy_add = -$signed({1'b0, 9'((mag + 14'd31) >> mvsm_pkg::VolShift)});
      end else begin
         fancy_add = $signed({1'b0, 9'(mag >> mvsm_pkg::VolShift)});
      end
      add_val = mode_ff[idx_ff] ? fancy_add : 10'(signed'(mem_rd));
   end

   // end-of-wave test
   logic [24:0] np;
   logic ends;
   assign np = {1'b0, pos_ff[idx_ff]} + 25'(rate_ff[idx_ff]);
   assign ends = mode_ff[idx_ff] ? (np >= {1'b0, last_ff[idx_ff], 8'd0}) :
                 ({1'b0, cur_idx} + 17'd1 > {1'b0, last_ff[idx_ff]});

   logic is_last;
   assign is_last = (32'(idx_ff) == NumVoices - 1);

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      sum_in = sum_ff;
      rsp_in = '0;
      unique case (state_ff)
         mvsm_pkg::S_IDLE: begin
            if (req_start) begin
               state_in = mvsm_pkg::S_SCAN;
               idx_in = '0;
               sum_in = '0;
            end
         end
         mvsm_pkg::S_SCAN: begin
            if (cmd_ff.command == mvsm_pkg::CMD_TICK) begin
               if (in_use_ff[idx_ff] && playing_ff[idx_ff]) begin
                  state_in = mvsm_pkg::S_READ;
               end else if (is_last) begin
                  state_in = mvsm_pkg::S_DONE;
               end else begin
                  idx_in = idx_ff + VW'(1);
               end
            end else begin
               state_in = mvsm_pkg::S_DONE;
            end
         end
         mvsm_pkg::S_READ: state_in = mvsm_pkg::S_ACC;
         mvsm_pkg::S_ACC: begin
            sum_in = sum_ff + 18'(add_val);
            if (is_last) begin
               state_in = mvsm_pkg::S_DONE;
            end else begin
               idx_in = idx_ff + VW'(1);
               state_in = mvsm_pkg::S_SCAN;
            end
         end
         mvsm_pkg::S_DONE: begin
            state_in = mvsm_pkg::S_IDLE;
            case (cmd_ff.command) inside
               mvsm_pkg::CMD_TICK: begin
                  if (sum_ff > 18'sd32767) begin
                     rsp_in.mix_sample = 16'sd32767;
                     rsp_in.clipped = 1'b1;
                  end else if (sum_ff < -18'sd32768) begin
                     rsp_in.mix_sample = -16'sd32768;
                     rsp_in.clipped = 1'b1;
                  end else begin
                     rsp_in.mix_sample = sum_ff[15:0];
                  end
               end
               mvsm_pkg::CMD_START: begin
                  if (free_found) rsp_in.voice_index = 4'(free_idx);
                  else rsp_in.status = mvsm_pkg::ST_FULL;
               end
               mvsm_pkg::CMD_QUERY: rsp_in.voice_active = addr_ok;
               mvsm_pkg::CMD_STOP, mvsm_pkg::CMD_PAUSE, mvsm_pkg::CMD_RESUME,
               mvsm_pkg::CMD_PLAY, mvsm_pkg::CMD_REWIND, mvsm_pkg::CMD_REPEAT,
               mvsm_pkg::CMD_POS, mvsm_pkg::CMD_RATE, mvsm_pkg::CMD_VOL: begin
                  if (!addr_ok) rsp_in.status = mvsm_pkg::ST_UNUSED;
               end
               default: ;
            endcase
         end
         default: state_in = mvsm_pkg::S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mvsm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= (state_ff == mvsm_pkg::S_DONE);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      sum_ff <= sum_in;
      rsp_ff <= rsp_in;
      if (state_ff == mvsm_pkg::S_IDLE && req_start) cmd_ff <= req;
   end

   // value clamps
   logic signed [15:0] rep_val;
   logic [15:0] pos_idx;
   logic [5:0] vol_val;
   logic [16:0] cnt;
   always_comb begin
      if (cmd_ff.value > 32'sd32767) rep_val = 16'sd32767;
      else if (cmd_ff.value < -32'sd32768) rep_val = -16'sd32768;
      else rep_val = cmd_ff.value[15:0];
      if (cmd_ff.value < 0) pos_idx = '0;
      else if (cmd_ff.value > 32'sd65535) pos_idx = 16'hFFFF;
      else pos_idx = cmd_ff.value[15:0];
      if (cmd_ff.value < 0) vol_val = '0;
      else if (cmd_ff.value > 32'sd63) vol_val = mvsm_pkg::VolMax;
      else vol_val = cmd_ff.value[5:0];
      if (cmd_ff.sample_count == '0) cnt = 17'd1;
      else if (cmd_ff.sample_count > 17'd65536) cnt = 17'd65536;
      else cnt = cmd_ff.sample_count;
   end

   // slot table updates; commands apply with their result so it sees the old table
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
         playing_ff <= '0;
         mode_ff <= '0;
         for (int i = 0; i < NumVoices; i++) begin
            start_ff[i] <= '0;
            last_ff[i] <= '0;
            pos_ff[i] <= '0;
            rate_ff[i] <= mvsm_pkg::RateReset;
            vol_ff[i] <= mvsm_pkg::VolReset;
            rep_ff[i] <= '0;
         end
      end else if (state_ff == mvsm_pkg::S_ACC) begin
         if (ends) begin
            if (rep_ff[idx_ff] == 16'sd0) begin
               in_use_ff[idx_ff] <= 1'b0;
               playing_ff[idx_ff] <= 1'b0;
            end else begin
               if (rep_ff[idx_ff] > 16'sd0) rep_ff[idx_ff] <= rep_ff[idx_ff] - 16'sd1;
               pos_ff[idx_ff] <= '0;
            end
         end else if (mode_ff[idx_ff]) begin
            pos_ff[idx_ff] <= np[23:0];
         end else begin
            pos_ff[idx_ff] <= pos_ff[idx_ff] + 24'd256;
         end
      end else if (state_ff == mvsm_pkg::S_DONE) begin
         if (cmd_ff.command == mvsm_pkg::CMD_START && free_found) begin
            in_use_ff[free_idx] <= 1'b1;
            playing_ff[free_idx] <= 1'b1;
            mode_ff[free_idx] <= cmd_ff.mode;
            start_ff[free_idx] <= cmd_ff.address;
            last_ff[free_idx] <= 16'(cnt - 17'd1);
            pos_ff[free_idx] <= '0;
            rate_ff[free_idx] <= mvsm_pkg::RateReset;
            vol_ff[free_idx] <= mvsm_pkg::VolReset;
            rep_ff[free_idx] <= '0;
         end else if (addr_ok) begin
            case (cmd_ff.command)
               mvsm_pkg::CMD_STOP: begin
                  in_use_ff[k] <= 1'b0;
                  playing_ff[k] <= 1'b0;
               end
               mvsm_pkg::CMD_PAUSE: playing_ff[k] <= 1'b0;
               mvsm_pkg::CMD_RESUME: playing_ff[k] <= 1'b1;
               mvsm_pkg::CMD_PLAY: begin
                  pos_ff[k] <= '0;
                  playing_ff[k] <= 1'b1;
               end
               mvsm_pkg::CMD_REWIND: pos_ff[k] <= '0;
               mvsm_pkg::CMD_REPEAT: rep_ff[k] <= rep_val;
               mvsm_pkg::CMD_POS: pos_ff[k] <= {pos_idx, pos_ff[k][7:0]};
               mvsm_pkg::CMD_RATE: rate_ff[k] <= cmd_ff.value[15:0];
               mvsm_pkg::CMD_VOL: vol_ff[k] <= vol_val;
               default: ;
            endcase
         end
      end
   end

   assign req_busy = (state_ff != mvsm_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

`include "multi_voice_sample_mixer_macros.svh"
   `MVSM_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == mvsm_pkg::S_DONE, rsp_valid)
   `MVSM_ASSERT_IMP(a_strobe_idle, clock, reset, rsp_valid, state_ff == mvsm_pkg::S_IDLE)
   `MVSM_ASSERT_NEXT(a_read_acc, clock, reset, state_ff == mvsm_pkg::S_READ, state_ff == mvsm_pkg::S_ACC)
endmodule
